FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define DSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication checked at every clock edge out of reset.
`define DSA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/dsa_pkg.sv
// Shared types and constants of the descriptor slot allocator.
package dsa_pkg;

    // Fixed field widths
    localparam int ADDR_W      = 64;
    localparam int CAP_W       = 11;
    localparam int STRIDE_W    = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int IN_TDATA_W  = 72;
    localparam int DIV_CNT_W   = 6;

    // Commands
    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CLEAN = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_FULL    = 3'd2,
        ST_BADADDR = 3'd3,
        ST_DEFFULL = 3'd4
    } status_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE  = 3'd4;

    // Configuration reset values
    localparam logic [CAP_W-1:0]    CAP_RESET    = 11'd1024;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd32;

endpackage

FILE: hw/rtl/descriptor_slot_allocator_unit.sv
// Descriptor slot allocator: free stack, deferred free lists and address math.
// Allocate reads the free stack, multiplies the slot by the stride and adds both bases; free
// subtracts the CPU base and divides by the stride in 64 divide steps on the shared adder; clean
// returns the listed slots one by one; the next item is taken after the result is registered.
// After reset an init pass loads the free stack with 0..depth-1; s_tready stays low
// meanwhile, configuration writes are taken throughout.
`include "assert_macros.svh"

module descriptor_slot_allocator_unit #(
    parameter int HEAP_DEPTH  = 1024,
    parameter int FRAME_COUNT = 3,
    localparam int SLOT_W     = $clog2(HEAP_DEPTH),
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1),
    localparam int OUT_BITS   = SLOT_W + 2 * dsa_pkg::ADDR_W + 2 * CNT_W,
    localparam int OUT_TD_W   = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // frame[1:0], handle_valid[2], handle_address[66:3], zero pad
    input  logic [dsa_pkg::IN_TDATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [1:0]                      s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // slot, cpu_address, gpu_address, returned_count, in_use, zero pad
    output logic [OUT_TD_W-1:0]             m_tdata,
    // status[2:0]
    output logic [2:0]                      m_tuser,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int FRM_W  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int DEF_D  = FRAME_COUNT * (2 ** SLOT_W);
    localparam int DEF_AW = $clog2(DEF_D);
    localparam int PROD_W = SLOT_W + dsa_pkg::STRIDE_W;
    localparam int REM_W  = dsa_pkg::STRIDE_W;
    localparam int AW     = dsa_pkg::ADDR_W;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ALC_RD,
        S_ALC_MUL,
        S_ALC_CPU,
        S_ALC_GPU,
        S_FREE_SUB,
        S_DIV,
        S_FREE_CHK,
        S_CLN_RD,
        S_CLN_WR,
        S_FINISH
    } state_t;

    // Configuration registers
    logic [dsa_pkg::CAP_W-1:0]    cap_reg;
    logic [dsa_pkg::STRIDE_W-1:0] stride_reg;
    logic [AW-1:0]                cpu_base_reg;
    logic [AW-1:0]                gpu_base_reg;
    logic                         visible_reg;

    // Control and working registers
    state_t                       state_reg, state_next;
    logic [SLOT_W-1:0]            init_idx_reg, init_idx_next;
    logic [CNT_W-1:0]             used_reg, used_next;
    logic [CNT_W-1:0]             total_reg, total_next;
    logic [CNT_W-1:0]             def_cnt_reg [FRAME_COUNT];
    logic [CNT_W-1:0]             def_cnt_next [FRAME_COUNT];
    logic [FRM_W-1:0]             frame_reg, frame_next;
    logic                         frame_ok_reg, frame_ok_next;
    logic [AW-1:0]                addr_reg, addr_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic [AW-1:0]                quot_reg, quot_next;
    logic [REM_W-1:0]             rem_reg, rem_next;
    logic [dsa_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]             cln_idx_reg, cln_idx_next;

    // Result being built
    dsa_pkg::status_t             res_status_reg, res_status_next;
    logic [SLOT_W-1:0]            res_slot_reg, res_slot_next;
    logic [AW-1:0]                res_cpu_reg, res_cpu_next;
    logic [AW-1:0]                res_gpu_reg, res_gpu_next;
    logic [CNT_W-1:0]             res_ret_reg, res_ret_next;

    // Output register
    logic                         m_valid_reg, m_valid_next;
    dsa_pkg::status_t             out_status_reg, out_status_next;
    logic [SLOT_W-1:0]            out_slot_reg, out_slot_next;
    logic [AW-1:0]                out_cpu_reg, out_cpu_next;
    logic [AW-1:0]                out_gpu_reg, out_gpu_next;
    logic [CNT_W-1:0]             out_ret_reg, out_ret_next;
    logic [CNT_W-1:0]             out_used_reg, out_used_next;

    // Input fields
    logic [1:0]                   in_frame;
    logic                         in_hvalid;
    logic [AW-1:0]                in_addr;
    dsa_pkg::cmd_t                in_cmd;

    // Shared adder
    logic [AW-1:0]                add_a, add_b;
    logic                         add_sub;
    logic [AW:0]                  add_res;
    logic                         add_carry;
    logic [AW-1:0]                add_sum;

    // Memories
    logic                         stk_we, stk_re;
    logic [SLOT_W-1:0]            stk_waddr, stk_wdata, stk_raddr, stk_rdata;
    logic                         def_we, def_re;
    logic [DEF_AW-1:0]            def_waddr, def_raddr;
    logic [SLOT_W-1:0]            def_wdata, def_rdata;

    logic [CNT_W-1:0]             cap_eff;
    logic [REM_W:0]               rem_shift;
    logic [CNT_W-1:0]             cur_cnt;
    logic                         in_fire;

    assign in_frame  = s_tdata[1:0];
    assign in_hvalid = s_tdata[2];
    assign in_addr   = s_tdata[66:3];
    assign in_cmd    = dsa_pkg::cmd_t'(s_tuser);

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Capacity clamped to the stack depth
    assign cap_eff = (int'(cap_reg) > HEAP_DEPTH) ? CNT_W'(HEAP_DEPTH) : CNT_W'(cap_reg);

    assign rem_shift = {rem_reg, quot_reg[AW-1]};
    assign cur_cnt   = def_cnt_reg[frame_reg];

    // Shared 64-bit add/subtract unit; carry set on subtract means no borrow
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            S_FREE_SUB:
            begin
                add_a   = addr_reg;
                add_b   = cpu_base_reg;
                add_sub = 1'b1;
            end
            S_DIV:
            begin
                add_a   = AW'(rem_shift);
                add_b   = AW'(stride_reg);
                add_sub = 1'b1;
            end
            S_ALC_CPU:
            begin
                add_a = cpu_base_reg;
                add_b = AW'(prod_reg);
            end
            S_ALC_GPU:
            begin
                add_a = gpu_base_reg;
                add_b = AW'(prod_reg);
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    assign add_res   = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                       + (AW + 1)'(add_sub);
    assign add_carry = add_res[AW];
    assign add_sum   = add_res[AW-1:0];

    // Free stack port control
    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = init_idx_reg;
        stk_wdata = init_idx_reg;
        if (state_reg == S_INIT)
        begin
            stk_we = 1'b1;
        end
        else if (state_reg == S_CLN_WR)
        begin
            stk_we    = 1'b1;
            stk_waddr = SLOT_W'(used_reg - 1'b1);
            stk_wdata = def_rdata;
        end
    end
    assign stk_re    = (state_reg == S_ALC_RD);
    assign stk_raddr = used_reg[SLOT_W-1:0];

    // Deferred list port control
    assign def_we    = (state_reg == S_FREE_CHK) && (rem_reg == '0)
                       && (quot_reg[AW-1:CNT_W] == '0) && (quot_reg[CNT_W-1:0] < cap_eff)
                       && frame_ok_reg && (total_reg < used_reg);
    assign def_waddr = DEF_AW'({frame_reg, cur_cnt[SLOT_W-1:0]});
    assign def_wdata = quot_reg[SLOT_W-1:0];
    assign def_re    = (state_reg == S_CLN_RD);
    assign def_raddr = DEF_AW'({frame_reg, cln_idx_reg[SLOT_W-1:0]});

    dsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (HEAP_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_en   (stk_re),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    dsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEF_D)
    ) u_deferred_ram (
        .clk     (clk),
        .wr_en   (def_we),
        .wr_addr (def_waddr),
        .wr_data (def_wdata),
        .rd_en   (def_re),
        .rd_addr (def_raddr),
        .rd_data (def_rdata)
    );

    // Sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        init_idx_next   = init_idx_reg;
        used_next       = used_reg;
        total_next      = total_reg;
        def_cnt_next    = def_cnt_reg;
        frame_next      = frame_reg;
        frame_ok_next   = frame_ok_reg;
        addr_next       = addr_reg;
        prod_next       = prod_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        cln_idx_next    = cln_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_cpu_next    = res_cpu_reg;
        res_gpu_next    = res_gpu_reg;
        res_ret_next    = res_ret_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_cpu_next    = out_cpu_reg;
        out_gpu_next    = out_gpu_reg;
        out_ret_next    = out_ret_reg;
        out_used_next   = out_used_reg;

        unique case (state_reg)
            // Load the free stack with identity values
            S_INIT:
            begin
                init_idx_next = init_idx_reg + 1'b1;
                if (init_idx_reg == SLOT_W'(HEAP_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            // Accept a command and decide its path
            S_IDLE:
            begin
                if (in_fire)
                begin
                    frame_next      = FRM_W'(in_frame);
                    frame_ok_next   = int'(in_frame) < FRAME_COUNT;
                    addr_next       = in_addr;
                    res_status_next = dsa_pkg::ST_OK;
                    res_slot_next   = '0;
                    res_cpu_next    = '0;
                    res_gpu_next    = '0;
                    res_ret_next    = '0;
                    unique case (in_cmd)
                        dsa_pkg::CMD_ALLOC:
                        begin
                            if (used_reg >= cap_eff)
                            begin
                                res_status_next = dsa_pkg::ST_FULL;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_ALC_RD;
                            end
                        end
                        dsa_pkg::CMD_FREE:
                        begin
                            if (!in_hvalid)
                            begin
                                res_status_next = dsa_pkg::ST_INVALID;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_FREE_SUB;
                            end
                        end
                        dsa_pkg::CMD_CLEAN:
                        begin
                            if (int'(in_frame) >= FRAME_COUNT)
                            begin
                                res_status_next = dsa_pkg::ST_DEFFULL;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                cln_idx_next = '0;
                                state_next   = S_CLN_RD;
                            end
                        end
                        dsa_pkg::CMD_NOP:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            // Allocate: pop the stack entry at used_count
            S_ALC_RD:
            begin
                used_next  = used_reg + 1'b1;
                state_next = S_ALC_MUL;
            end

            S_ALC_MUL:
            begin
                res_slot_next = stk_rdata;
                prod_next     = PROD_W'(stk_rdata) * PROD_W'(stride_reg);
                state_next    = S_ALC_CPU;
            end

            S_ALC_CPU:
            begin
                res_cpu_next = add_sum;
                state_next   = S_ALC_GPU;
            end

            S_ALC_GPU:
            begin
                res_gpu_next = visible_reg ? add_sum : '0;
                state_next   = S_FINISH;
            end

            // Free: offset from base, then bit-serial divide by the stride
            S_FREE_SUB:
            begin
                if (!add_carry || (stride_reg == '0))
                begin
                    res_status_next = dsa_pkg::ST_BADADDR;
                    state_next      = S_FINISH;
                end
                else
                begin
                    quot_next    = add_sum;
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end

            S_DIV:
            begin
                if (add_carry)
                begin
                    rem_next  = add_sum[REM_W-1:0];
                    quot_next = {quot_reg[AW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift[REM_W-1:0];
                    quot_next = {quot_reg[AW-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == dsa_pkg::DIV_CNT_W'(AW - 1))
                begin
                    state_next = S_FREE_CHK;
                end
            end

            // Range and alignment check, then queue on the frame's list
            S_FREE_CHK:
            begin
                if ((rem_reg != '0) || (quot_reg[AW-1:CNT_W] != '0)
                    || (quot_reg[CNT_W-1:0] >= cap_eff))
                begin
                    res_status_next = dsa_pkg::ST_BADADDR;
                end
                else if (!frame_ok_reg || (total_reg >= used_reg))
                begin
                    res_status_next = dsa_pkg::ST_DEFFULL;
                end
                else
                begin
                    def_cnt_next[frame_reg] = cur_cnt + 1'b1;
                    total_next              = total_reg + 1'b1;
                    res_slot_next           = quot_reg[SLOT_W-1:0];
                end
                state_next = S_FINISH;
            end

            // Clean: walk the list, reading each slot and pushing it back on the free stack
            S_CLN_RD:
            begin
                if ((cln_idx_reg < cur_cnt) && (used_reg != '0))
                begin
                    state_next = S_CLN_WR;
                end
                else
                begin
                    res_ret_next            = cln_idx_reg;
                    def_cnt_next[frame_reg] = '0;
                    total_next              = total_reg - cur_cnt;
                    state_next              = S_FINISH;
                end
            end

            S_CLN_WR:
            begin
                used_next    = used_reg - 1'b1;
                cln_idx_next = cln_idx_reg + 1'b1;
                state_next   = S_CLN_RD;
            end

            // Hand the result to the output register once it is free
            S_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_cpu_next    = res_cpu_reg;
                    out_gpu_next    = res_gpu_reg;
                    out_ret_next    = res_ret_reg;
                    out_used_next   = used_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            init_idx_reg <= '0;
            used_reg     <= '0;
            total_reg    <= '0;
            for (int f = 0; f < FRAME_COUNT; f++)
            begin
                def_cnt_reg[f] <= '0;
            end
            m_valid_reg  <= 1'b0;
            cap_reg      <= dsa_pkg::CAP_RESET;
            stride_reg   <= dsa_pkg::STRIDE_RESET;
            cpu_base_reg <= '0;
            gpu_base_reg <= '0;
            visible_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            init_idx_reg <= init_idx_next;
            used_reg     <= used_next;
            total_reg    <= total_next;
            def_cnt_reg  <= def_cnt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    dsa_pkg::CFG_CAPACITY: cap_reg      <= cfg_data[dsa_pkg::CAP_W-1:0];
                    dsa_pkg::CFG_STRIDE:   stride_reg   <= cfg_data[dsa_pkg::STRIDE_W-1:0];
                    dsa_pkg::CFG_CPU_BASE: cpu_base_reg <= cfg_data;
                    dsa_pkg::CFG_GPU_BASE: gpu_base_reg <= cfg_data;
                    dsa_pkg::CFG_VISIBLE:  visible_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        frame_reg      <= frame_next;
        frame_ok_reg   <= frame_ok_next;
        addr_reg       <= addr_next;
        prod_reg       <= prod_next;
        quot_reg       <= quot_next;
        rem_reg        <= rem_next;
        div_cnt_reg    <= div_cnt_next;
        cln_idx_reg    <= cln_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_cpu_reg    <= res_cpu_next;
        res_gpu_reg    <= res_gpu_next;
        res_ret_reg    <= res_ret_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_cpu_reg    <= out_cpu_next;
        out_gpu_reg    <= out_gpu_next;
        out_ret_reg    <= out_ret_next;
        out_used_reg   <= out_used_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = OUT_TD_W'({out_used_reg, out_ret_reg, out_gpu_reg, out_cpu_reg,
                                 out_slot_reg});

    // Between items, deferred slots never outnumber outstanding allocations
    `DSA_ASSERT_IMPL(a_total_le_used, state_reg == S_IDLE, total_reg <= used_reg, "deferred total exceeds used count")

    // A deferred write only happens with an allocation left to cover it
    `DSA_ASSERT_IMPL(a_def_write_room, def_we, total_reg < used_reg, "deferred push without room")

    // The used count moves by at most one per cycle
    `DSA_ASSERT_IMPL(a_used_step, used_reg != $past(used_reg),
        (used_reg == CNT_W'($past(used_reg) + 1'b1)) || (used_reg == CNT_W'($past(used_reg) - 1'b1)),
        "used count jumped")

endmodule

FILE: hw/rtl/dsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dsa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: bench/dsa_slot_ledger.sv
// Result checker for the descriptor slot allocator: tracks slot state and compares results.
module dsa_slot_ledger
    import dsa_pkg::*;
#(
    parameter int HEAP_DEPTH  = 1024,
    parameter int FRAME_COUNT = 3,
    localparam int SLOT_W     = $clog2(HEAP_DEPTH),
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1),
    localparam int OUT_BITS   = SLOT_W + 2 * ADDR_W + 2 * CNT_W,
    localparam int OUT_TD_W   = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TD_W-1:0]    m_tdata,
    input  logic [2:0]             m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   drain_done,
    output int unsigned            results_seen,
    output int unsigned            failures
);

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [ADDR_W-1:0]  cpu_addr;
        logic [ADDR_W-1:0]  gpu_addr;
        logic [CNT_W-1:0]   returned;
        logic [CNT_W-1:0]   in_use;
    } slot_result_t;

    // Register copies
    logic [CAP_W-1:0]     capacity;
    logic [STRIDE_W-1:0]  stride;
    logic [ADDR_W-1:0]    cpu_base;
    logic [ADDR_W-1:0]    gpu_base;
    logic                 visible;

    // Allocator state
    logic [SLOT_W-1:0]    free_slots [HEAP_DEPTH];
    int unsigned          live_count;
    logic [SLOT_W-1:0]    deferred [FRAME_COUNT][HEAP_DEPTH];
    int unsigned          defer_count [FRAME_COUNT];

    slot_result_t         awaited_results [$];
    slot_result_t         next_result;
    slot_result_t         seen_result;
    bit                   drain_checked;

    // One line per mismatch
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at result %0d: %s got %h expected %h",
                 results_seen, what, got, want);
        failures++;
    endtask

    // Apply one request to the tracked state and build the result it gives
    task automatic apply_request(input cmd_t op, input logic [1:0] fr, input logic hv,
                                 input logic [ADDR_W-1:0] addr, output slot_result_t r);
        int unsigned cap_eff;
        int unsigned outstanding;
        int unsigned n;
        int unsigned i;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] diff;
        logic [ADDR_W-1:0] quot;
        r = '0;
        r.status = ST_OK;
        cap_eff = (capacity > HEAP_DEPTH) ? HEAP_DEPTH : capacity;
        outstanding = 0;
        for (i = 0; i < FRAME_COUNT; i++)
            outstanding += defer_count[i];
        case (op)
            CMD_ALLOC:
            begin
                if (live_count >= cap_eff)
                    r.status = ST_FULL;
                else
                begin
                    r.slot = free_slots[live_count];
                    live_count++;
                    offset = ADDR_W'(r.slot) * ADDR_W'(stride);
                    r.cpu_addr = cpu_base + offset;
                    r.gpu_addr = visible ? gpu_base + offset : '0;
                end
            end
            CMD_FREE:
            begin
                if (!hv)
                    r.status = ST_INVALID;
                else if (addr < cpu_base || stride == 0)
                    r.status = ST_BADADDR;
                else
                begin
                    diff = addr - cpu_base;
                    quot = diff / ADDR_W'(stride);
                    if (diff % ADDR_W'(stride) != 0 || quot >= ADDR_W'(cap_eff))
                        r.status = ST_BADADDR;
                    else if (fr >= FRAME_COUNT || outstanding >= live_count)
                        r.status = ST_DEFFULL;
                    else
                    begin
                        deferred[fr][defer_count[fr]] = quot[SLOT_W-1:0];
                        defer_count[fr]++;
                        r.slot = quot[SLOT_W-1:0];
                    end
                end
            end
            CMD_CLEAN:
            begin
                if (fr >= FRAME_COUNT)
                    r.status = ST_DEFFULL;
                else
                begin
                    // return in list order, never below zero in use
                    n = defer_count[fr];
                    i = 0;
                    while (i < n && live_count > 0)
                    begin
                        live_count--;
                        free_slots[live_count] = deferred[fr][i];
                        i++;
                    end
                    r.returned = CNT_W'(i);
                    defer_count[fr] = 0;
                end
            end
            default:
            begin
            end
        endcase
        r.in_use = CNT_W'(live_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity = CAP_RESET;
            stride = STRIDE_RESET;
            cpu_base = '0;
            gpu_base = '0;
            visible = 1'b0;
            for (int i = 0; i < HEAP_DEPTH; i++)
                free_slots[i] = SLOT_W'(i);
            live_count = 0;
            for (int f = 0; f < FRAME_COUNT; f++)
                defer_count[f] = 0;
            awaited_results.delete();
            drain_checked = 1'b0;
            results_seen <= 0;
        end
        else
        begin
            // Register write transaction
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CAPACITY: capacity = cfg_data[CAP_W-1:0];
                    CFG_STRIDE:   stride = cfg_data[STRIDE_W-1:0];
                    CFG_CPU_BASE: cpu_base = cfg_data;
                    CFG_GPU_BASE: gpu_base = cfg_data;
                    CFG_VISIBLE:  visible = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            // Request transaction
            if (s_tvalid && s_tready)
            begin
                apply_request(cmd_t'(s_tuser), s_tdata[1:0], s_tdata[2], s_tdata[66:3],
                              next_result);
                awaited_results.insert(awaited_results.size(), next_result);
            end

            // Result transaction
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (awaited_results.size() == 0)
                    report_mismatch("unexpected result, status", 64'(m_tuser), 64'd0);
                else
                begin
                    seen_result = awaited_results.pop_front();
                    if (m_tuser !== seen_result.status)
                        report_mismatch("status", 64'(m_tuser), 64'(seen_result.status));
                    if (m_tdata[SLOT_W-1:0] !== seen_result.slot)
                        report_mismatch("slot", 64'(m_tdata[SLOT_W-1:0]),
                                        64'(seen_result.slot));
                    if (m_tdata[SLOT_W +: ADDR_W] !== seen_result.cpu_addr)
                        report_mismatch("cpu_address", m_tdata[SLOT_W +: ADDR_W],
                                        seen_result.cpu_addr);
                    if (m_tdata[SLOT_W + ADDR_W +: ADDR_W] !== seen_result.gpu_addr)
                        report_mismatch("gpu_address", m_tdata[SLOT_W + ADDR_W +: ADDR_W],
                                        seen_result.gpu_addr);
                    if (m_tdata[SLOT_W + 2 * ADDR_W +: CNT_W] !== seen_result.returned)
                        report_mismatch("returned_count",
                                        64'(m_tdata[SLOT_W + 2 * ADDR_W +: CNT_W]),
                                        64'(seen_result.returned));
                    if (m_tdata[SLOT_W + 2 * ADDR_W + CNT_W +: CNT_W] !== seen_result.in_use)
                        report_mismatch("in_use",
                                        64'(m_tdata[SLOT_W + 2 * ADDR_W + CNT_W +: CNT_W]),
                                        64'(seen_result.in_use));
                end
            end

            // Anything still awaited at the end is missing
            if (drain_done && !drain_checked)
            begin
                drain_checked = 1'b1;
                if (awaited_results.size() != 0)
                    report_mismatch("results never delivered, count",
                                    64'(awaited_results.size()), 64'd0);
            end
        end
    end

endmodule

FILE: bench/descriptor_slot_allocator_unit_tb.sv
// Testbench top for the descriptor slot allocator: stimulus, flow control and verdict.
module descriptor_slot_allocator_unit_tb;
    import dsa_pkg::*;

    localparam int HEAP_DEPTH     = 1024;
    localparam int FRAME_COUNT    = 3;
    localparam int SLOT_W         = $clog2(HEAP_DEPTH);
    localparam int CNT_W          = $clog2(HEAP_DEPTH + 1);
    localparam int OUT_TD_W       = ((SLOT_W + 2 * ADDR_W + 2 * CNT_W + 7) / 8) * 8;
    localparam int TIMEOUT_CYCLES = 2_000_000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TD_W-1:0]    m_tdata;
    logic [2:0]             m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   drain_done;
    int unsigned            results_seen;
    int unsigned            failures;

    // Stimulus bookkeeping
    int unsigned            items_sent;
    int unsigned            gap_pct;
    int unsigned            calm_items;
    bit                     rx_calm;
    int unsigned            tb_cap;
    logic [STRIDE_W-1:0]    tb_stride;
    logic [ADDR_W-1:0]      tb_cpu_base;

    descriptor_slot_allocator_unit #(
        .HEAP_DEPTH  (HEAP_DEPTH),
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dsa_slot_ledger #(
        .HEAP_DEPTH  (HEAP_DEPTH),
        .FRAME_COUNT (FRAME_COUNT)
    ) u_ledger (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .drain_done   (drain_done),
        .results_seen (results_seen),
        .failures     (failures)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #(2 * TIMEOUT_CYCLES);
        $display("descriptor_slot_allocator_unit test failed");
        $finish;
    end

    // Result side backpressure: random stall bursts with calm windows
    initial
    begin : result_backpressure
        int unsigned hold;
        int unsigned calm_cycles;
        hold = 0;
        calm_cycles = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (calm_cycles > 0)
                calm_cycles--;
            else if (!rx_calm && $urandom_range(0, 199) == 0)
                calm_cycles = $urandom_range(100, 500);
            else if (!rx_calm && $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, 17);
            m_tready <= rx_calm || (hold == 0);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // One request transaction; may open with an idle burst
    task automatic send_item(input cmd_t c, input logic [1:0] fr, input logic hv,
                             input logic [ADDR_W-1:0] a);
        if (calm_items > 0)
            calm_items--;
        else if (gap_pct != 0 && $urandom_range(0, 49) == 0)
            calm_items = $urandom_range(20, 60);
        else if ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= {5'd0, a, hv, fr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Hold the sender until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_seen < items_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Full register setting, only with the block idle
    task automatic set_config(input logic [CAP_W-1:0] cap, input logic [STRIDE_W-1:0] strd,
                              input logic [ADDR_W-1:0] cbase, input logic [ADDR_W-1:0] gbase,
                              input logic vis);
        wait_drained();
        write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
        write_reg(CFG_STRIDE, CFG_DATA_W'(strd));
        write_reg(CFG_CPU_BASE, cbase);
        write_reg(CFG_GPU_BASE, gbase);
        write_reg(CFG_VISIBLE, CFG_DATA_W'(vis));
        tb_cap = cap;
        tb_stride = strd;
        tb_cpu_base = cbase;
    endtask

    // Mostly well-formed traffic: frees aim at real slot addresses
    task automatic send_random();
        int unsigned pick;
        int unsigned cap_eff;
        logic [1:0] fr;
        logic hv;
        logic [ADDR_W-1:0] a;
        pick = $urandom_range(0, 99);
        cap_eff = (tb_cap > HEAP_DEPTH) ? HEAP_DEPTH : tb_cap;
        fr = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, FRAME_COUNT - 1));
        hv = ($urandom_range(0, 15) != 0);
        a = tb_cpu_base + ADDR_W'($urandom_range(0, cap_eff)) * ADDR_W'(tb_stride);
        case ($urandom_range(0, 9))
            0: a = rand64();
            1: a = a + ADDR_W'($urandom_range(1, 3));
            2: a = tb_cpu_base - ADDR_W'($urandom_range(1, 64));
            default:
            begin
            end
        endcase
        if (pick < 42)
            send_item(CMD_ALLOC, fr, hv, rand64());
        else if (pick < 80)
            send_item(CMD_FREE, fr, hv, a);
        else if (pick < 95)
            send_item(CMD_CLEAN, fr, hv, rand64());
        else
            send_item(CMD_NOP, fr, hv, a);
    endtask

    // Main sequence
    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= CMD_NOP;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_CAPACITY;
        cfg_data <= '0;
        drain_done <= 1'b0;
        items_sent = 0;
        gap_pct = 30;
        calm_items = 0;
        rx_calm = 1'b0;
        tb_cap = 1024;
        tb_stride = STRIDE_RESET;
        tb_cpu_base = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sequence on reset settings
        send_item(CMD_ALLOC, 2'd0, 1'b0, '0);
        send_item(CMD_ALLOC, 2'd0, 1'b0, '0);
        send_item(CMD_ALLOC, 2'd0, 1'b0, '0);
        send_item(CMD_NOP, 2'd3, 1'b1, '1);
        send_item(CMD_FREE, 2'd0, 1'b0, '1);               // invalid handle
        send_item(CMD_FREE, 2'd0, 1'b1, 64'd33);           // misaligned
        send_item(CMD_FREE, 2'd0, 1'b1, 64'd1024 * 64'd32); // past capacity
        send_item(CMD_FREE, 2'd0, 1'b1, '1);
        send_item(CMD_FREE, 2'd3, 1'b1, 64'd32);           // frame out of range
        send_item(CMD_FREE, 2'd0, 1'b1, 64'd1023 * 64'd32); // top slot
        send_item(CMD_FREE, 2'd1, 1'b1, 64'd0);
        send_item(CMD_FREE, 2'd1, 1'b1, 64'd0);            // double free
        send_item(CMD_FREE, 2'd2, 1'b1, 64'd64);           // nothing outstanding
        send_item(CMD_CLEAN, 2'd3, 1'b0, '0);
        send_item(CMD_CLEAN, 2'd0, 1'b0, '0);
        send_item(CMD_CLEAN, 2'd1, 1'b0, '0);
        send_item(CMD_CLEAN, 2'd2, 1'b0, '0);
        send_item(CMD_ALLOC, 2'd0, 1'b0, '0);
        send_item(CMD_ALLOC, 2'd0, 1'b0, '0);
        send_item(CMD_ALLOC, 2'd0, 1'b0, '0);

        // Small visible heap: run it full, free below base, then random
        set_config(11'd8, 13'd64, 64'h0000_0000_1000_0000, rand64(), 1'b1);
        repeat (7) send_item(CMD_ALLOC, 2'd0, 1'b0, '0);
        send_item(CMD_FREE, 2'd0, 1'b1, tb_cpu_base - 64'd64);
        repeat (150) send_random();

        // Sender holds off until all results are in, mid-phase
        wait_drained();
        gap_pct = 50;
        repeat (30) send_random();

        // Capacity zero with stride zero
        set_config(11'd0, 13'd0, rand64(), rand64(), 1'b0);
        repeat (30) send_random();

        // Capacity above depth, widest stride, addresses that wrap
        set_config(11'h7FF, 13'h1FFF, 64'hFFFF_FFFF_FFFF_8000, '1, 1'b1);
        gap_pct = 20;
        repeat (150) send_random();

        // Single slot, unit stride
        set_config(11'd1, 13'd1, '0, '0, 1'b0);
        repeat (60) send_random();

        // Random settings
        repeat (3)
        begin
            set_config(11'($urandom_range(1, 1024)), 13'($urandom_range(1, 4096)),
                       rand64(), rand64(), 1'($urandom_range(0, 1)));
            gap_pct = $urandom_range(10, 60);
            repeat (120) send_random();
        end

        // Last part without idling on either side
        set_config(11'd1024, 13'd32, rand64(), rand64(), 1'b1);
        gap_pct = 0;
        rx_calm = 1'b1;
        repeat (100) send_random();

        // Drain and verdict
        wait_drained();
        repeat (80) @(posedge clk);
        drain_done <= 1'b1;
        repeat (3) @(posedge clk);
        if (failures == 0)
            $display("descriptor_slot_allocator_unit test passed");
        else
            $display("descriptor_slot_allocator_unit test failed");
        $finish;
    end

endmodule
